/* hw/rtl/polyline_miter_offset_defines.svh */
// Assertion helpers for polyline_miter_offset.sv; clk_i and rst_ni must be in scope.
`ifndef POLYLINE_MITER_OFFSET_DEFINES_SVH
`define POLYLINE_MITER_OFFSET_DEFINES_SVH

`define PLMO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define PLMO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/plmo_pkg.sv */
package plmo_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned INDEX_BITS_DEF = 16;

  localparam int unsigned DW         = 64;
  localparam int unsigned MUL_STEPS  = 33;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CNT_W      = 7;

  localparam logic [DW-1:0] RMAX      = 64'd1 << 38;
  localparam logic [DW+1:0] MUL_LIMIT = 66'd1 << 62;

  localparam logic [1:0] CFG_IS_POLYGON    = 2'd0;
  localparam logic [1:0] CFG_OFFSET_AMOUNT = 2'd1;
  localparam logic [1:0] CFG_DEPTH_SCALING = 2'd2;

  typedef enum logic [2:0] {
    ALU_MUL  = 3'b001,
    ALU_DIV  = 3'b010,
    ALU_SQRT = 3'b100
  } alu_op_e;

  typedef struct packed {
    logic          start;
    alu_op_e       op;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic          big;
    logic [DW-1:0] res;
  } alu_rsp_t;

endpackage

/* hw/rtl/plmo_alu.sv */
module plmo_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plmo_pkg::alu_req_t req_i,
  output plmo_pkg::alu_rsp_t rsp_o
);

  logic                             busy_q, done_q, big_q;
  plmo_pkg::alu_op_e                op_q;
  logic [plmo_pkg::CNT_W-1:0]       cnt_q;
  logic [plmo_pkg::DW-1:0]          acc_q, a_q, b_q;
  logic [plmo_pkg::DW:0]            rem_q;

  logic [plmo_pkg::DW+1:0]          mul_nxt;
  logic                             mul_big;
  logic [plmo_pkg::DW:0]            div_trial;
  logic                             div_ge;
  logic [plmo_pkg::DW:0]            sq_rem, sq_test;
  logic                             sq_ge;
  logic [plmo_pkg::CNT_W-1:0]       steps;

  always_comb begin
    mul_nxt   = {1'b0, acc_q, 1'b0}
              + (b_q[plmo_pkg::MUL_STEPS-1] ? {2'b00, a_q} : '0);
    mul_big   = mul_nxt > plmo_pkg::MUL_LIMIT;
    div_trial = {rem_q[plmo_pkg::DW-1:0], a_q[plmo_pkg::DW-1]};
    div_ge    = div_trial >= {1'b0, b_q};
    sq_rem    = {rem_q[plmo_pkg::DW-2:0], a_q[plmo_pkg::DW-1 -: 2]};
    sq_test   = {acc_q[plmo_pkg::DW-2:0], 2'b01};
    sq_ge     = sq_rem >= sq_test;
    unique case (req_i.op)
      plmo_pkg::ALU_MUL:  steps = plmo_pkg::CNT_W'(plmo_pkg::MUL_STEPS);
      plmo_pkg::ALU_DIV:  steps = plmo_pkg::CNT_W'(plmo_pkg::DIV_STEPS);
      plmo_pkg::ALU_SQRT: steps = plmo_pkg::CNT_W'(plmo_pkg::SQRT_STEPS);
      default:            steps = plmo_pkg::CNT_W'(plmo_pkg::MUL_STEPS);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= plmo_pkg::ALU_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == plmo_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
      rem_q <= '0;
      big_q <= 1'b0;
    end else if (busy_q) begin
      unique case (op_q)
        plmo_pkg::ALU_MUL: begin
          b_q <= b_q << 1;
          if (big_q || mul_big) big_q <= 1'b1;
          else acc_q <= mul_nxt[plmo_pkg::DW-1:0];
        end
        plmo_pkg::ALU_DIV: begin
          a_q <= a_q << 1;
          if (div_ge) begin
            rem_q <= div_trial - {1'b0, b_q};
            acc_q <= {acc_q[plmo_pkg::DW-2:0], 1'b1};
          end else begin
            rem_q <= div_trial;
            acc_q <= {acc_q[plmo_pkg::DW-2:0], 1'b0};
          end
        end
        plmo_pkg::ALU_SQRT: begin
          a_q <= a_q << 2;
          if (sq_ge) begin
            rem_q <= sq_rem - sq_test;
            acc_q <= {acc_q[plmo_pkg::DW-2:0], 1'b1};
          end else begin
            rem_q <= sq_rem;
            acc_q <= {acc_q[plmo_pkg::DW-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.big  = big_q;
  assign rsp_o.res  = acc_q;

endmodule

/* hw/rtl/polyline_miter_offset.sv */
// Polyline / polygon miter-join offset in the XY plane, fixed point Q(FRAC_BITS).
// Input stream s_axis_*: one vertex per item, tlast marks the final vertex of a figure.
// Output stream m_axis_*: offset vertices, tlast on the final one of the figure, tuser set
// when a one-vertex figure is passed through unchanged. Results lag input by one vertex;
// for a closed polygon vertex 0 comes last. Configuration port cfg_*: index 0 polygon mode,
// 1 offset amount, 2 depth scaling; always ready, write only between figures.
// One vertex at a time: s_axis_tready is high only while the block waits for a vertex.
// Multiplies, divides and square roots all run on one shared serial unit, and the
// sequencer waits for each to finish. Depth scaling adds a divide to every end placement
// and miter join. A one-vertex figure gives its result in the cycle after it is accepted.
// The result is held in the output register until m_axis_tready; nothing further is
// computed meanwhile. Reset drops any figure in progress and restores the default
// configuration: polyline, offset 1.0 at the default FRAC_BITS, no depth scaling.
module polyline_miter_offset #(
  parameter int unsigned FRAC_BITS  = plmo_pkg::FRAC_BITS_DEF,
  parameter int unsigned INDEX_BITS = plmo_pkg::INDEX_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // x_in, y_in, z_in
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // x_out, y_out, z_out, vertex_index
  output logic         m_axis_tlast,
  output logic [0:0]   m_axis_tuser,   // degenerate
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  `include "polyline_miter_offset_defines.svh"

  localparam logic [63:0] ONE       = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TWO_ONE   = 64'd1 << (FRAC_BITS + 1);
  localparam logic [63:0] ONE_SQ    = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] MITER_MIN = 64'(((2 ** FRAC_BITS) + 50) / 100);
  localparam logic [33:0] TEN       = 34'(10 * (2 ** FRAC_BITS));

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_U_PREP = 18'h00002,
    S_U_MX   = 18'h00004,
    S_U_MY   = 18'h00008,
    S_U_SQ   = 18'h00010,
    S_U_DX   = 18'h00020,
    S_U_DY   = 18'h00040,
    S_U_END  = 18'h00080,
    S_M_DX   = 18'h00100,
    S_M_DY   = 18'h00200,
    S_M_SQ   = 18'h00400,
    S_P_KF   = 18'h00800,
    S_P_NUM  = 18'h01000,
    S_P_Q    = 18'h02000,
    S_P_MY   = 18'h04000,
    S_P_MX   = 18'h08000,
    S_OUT    = 18'h10000,
    S_MAIN   = 18'h20000
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ONE  = 3'b010,
    PH_RUN  = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    J_DIR   = 3'b001,
    J_BIS   = 3'b010,
    J_CLOSE = 3'b100
  } job_e;

  typedef enum logic [2:0] {
    N_MAIN   = 3'b001,
    N_CLOSE2 = 3'b010,
    N_FIN    = 3'b100
  } nxt_e;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? 33'(~v + 33'd1) : v;
  endfunction

  function automatic logic [31:0] clamp41(input logic signed [40:0] v);
    if (v > 41'sd2147483647) return 32'h7fffffff;
    if (v < -41'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] satm(input logic big, input logic [63:0] p);
    logic [63:0] sh;
    sh = p >> FRAC_BITS;
    if (big || sh > plmo_pkg::RMAX) return plmo_pkg::RMAX;
    return sh;
  endfunction

  state_e state_q;
  phase_e phase_q;
  job_e   job_q;
  nxt_e   nxt_q;
  logic   issued_q;

  logic        poly_q, depth_q;
  logic [31:0] off_q;

  logic signed [31:0] in_q [3];
  logic               inlast_q;
  logic signed [31:0] first_q [3];
  logic signed [31:0] pend_q [3];
  logic signed [31:0] pt_q [3];
  logic signed [31:0] fdir_q [2];
  logic signed [31:0] pdir_q [2];
  logic signed [31:0] d_q [2];
  logic signed [31:0] c_q [2];
  logic signed [31:0] va_q [2];
  logic signed [31:0] vb_q [2];
  logic signed [31:0] resx_q, resy_q, bx_q, by_q;
  logic [32:0]        dx_q, dy_q, ux_q, uy_q;
  logic               uxn_q, uyn_q, numneg_q;
  logic [63:0]        sq_q, s_q, kf_q, m_q, q_q;
  logic [31:0]        len_q;
  logic signed [63:0] dot_q;

  logic [INDEX_BITS-1:0] cnt_q, idx_q, idxp_q;
  logic                  olast_q;

  logic [31:0]           xo_q, yo_q, zo_q;
  logic [INDEX_BITS-1:0] io_q;
  logic                  lo_q, dg_q;

  plmo_pkg::alu_req_t alu_req;
  plmo_pkg::alu_rsp_t alu_rsp;
  logic               alu_state;

  logic [32:0]        ux_w, uy_w, uor_w, zmag_w;
  logic signed [63:0] tdot_w, t_w;
  logic [63:0]        tcl_w, m2_w, res_neg_w;
  logic signed [40:0] sumx_w, sumy_w;
  logic [33:0]        zz_w;
  logic               in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    ux_w   = mag33(dx_q);
    uy_w   = mag33(dy_q);
    uor_w  = ux_w | uy_w;
    tdot_w = dot_q >>> FRAC_BITS;
    t_w    = $signed(ONE) + tdot_w;
    if (t_w < 0) tcl_w = '0;
    else if (t_w > $signed(TWO_ONE)) tcl_w = TWO_ONE;
    else tcl_w = t_w;
    zz_w   = {{2{pt_q[2][31]}}, pt_q[2]} + TEN;
    zmag_w = zz_w[33] ? 33'(~zz_w + 34'd1) : zz_w[32:0];
    m2_w   = satm(alu_rsp.big, alu_rsp.res);
    res_neg_w = ~alu_rsp.res + 64'd1;
    sumx_w = 41'(pt_q[0]) + (((by_q[31] ^ numneg_q) ? -$signed(41'(m2_w)) :
                               $signed(41'(m2_w))));
    sumy_w = 41'(pt_q[1]) - (((bx_q[31] ^ numneg_q) ? -$signed(41'(m2_w)) :
                               $signed(41'(m2_w))));
  end

  always_comb begin
    alu_req.op = plmo_pkg::ALU_MUL;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_state  = 1'b1;
    unique case (state_q)
      S_U_MX: begin
        alu_req.a = 64'(ux_q);
        alu_req.b = 64'(ux_q);
      end
      S_U_MY: begin
        alu_req.a = 64'(uy_q);
        alu_req.b = 64'(uy_q);
      end
      S_U_SQ: begin
        alu_req.op = plmo_pkg::ALU_SQRT;
        alu_req.a  = sq_q;
      end
      S_U_DX: begin
        alu_req.op = plmo_pkg::ALU_DIV;
        alu_req.a  = 64'(ux_q) << FRAC_BITS;
        alu_req.b  = 64'(len_q);
      end
      S_U_DY: begin
        alu_req.op = plmo_pkg::ALU_DIV;
        alu_req.a  = 64'(uy_q) << FRAC_BITS;
        alu_req.b  = 64'(len_q);
      end
      S_M_DX: begin
        alu_req.a = 64'(mag33({va_q[0][31], va_q[0]}));
        alu_req.b = 64'(mag33({vb_q[0][31], vb_q[0]}));
      end
      S_M_DY: begin
        alu_req.a = 64'(mag33({va_q[1][31], va_q[1]}));
        alu_req.b = 64'(mag33({vb_q[1][31], vb_q[1]}));
      end
      S_M_SQ: begin
        alu_req.op = plmo_pkg::ALU_SQRT;
        alu_req.a  = tcl_w << (FRAC_BITS - 1);
      end
      S_P_KF: begin
        alu_req.op = plmo_pkg::ALU_DIV;
        alu_req.a  = ONE_SQ;
        alu_req.b  = 64'(zmag_w) + 64'd1;
        alu_state  = depth_q;
      end
      S_P_NUM: begin
        alu_req.a = kf_q;
        alu_req.b = 64'(mag33({off_q[31], off_q}));
      end
      S_P_Q: begin
        alu_req.op = plmo_pkg::ALU_DIV;
        alu_req.a  = m_q << FRAC_BITS;
        alu_req.b  = s_q;
      end
      S_P_MY: begin
        alu_req.a = q_q;
        alu_req.b = 64'(mag33({by_q[31], by_q}));
      end
      S_P_MX: begin
        alu_req.a = q_q;
        alu_req.b = 64'(mag33({bx_q[31], bx_q}));
      end
      default: alu_state = 1'b0;
    endcase
    alu_req.start = alu_state && !issued_q;
  end

  plmo_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_IDLE;
      job_q    <= J_DIR;
      nxt_q    <= N_FIN;
      issued_q <= 1'b0;
      cnt_q    <= '0;
      poly_q   <= 1'b0;
      depth_q  <= 1'b0;
      off_q    <= 32'h00010000;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          plmo_pkg::CFG_IS_POLYGON:    poly_q  <= cfg_data_i[0];
          plmo_pkg::CFG_OFFSET_AMOUNT: off_q   <= cfg_data_i;
          plmo_pkg::CFG_DEPTH_SCALING: depth_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (alu_req.start) issued_q <= 1'b1;
      if (alu_rsp.done) issued_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            in_q[0]  <= s_axis_tdata[31:0];
            in_q[1]  <= s_axis_tdata[63:32];
            in_q[2]  <= s_axis_tdata[95:64];
            inlast_q <= s_axis_tlast;
            if (phase_q == PH_IDLE) begin
              first_q[0] <= s_axis_tdata[31:0];
              first_q[1] <= s_axis_tdata[63:32];
              first_q[2] <= s_axis_tdata[95:64];
              pend_q[0]  <= s_axis_tdata[31:0];
              pend_q[1]  <= s_axis_tdata[63:32];
              pend_q[2]  <= s_axis_tdata[95:64];
              if (s_axis_tlast) begin
                xo_q    <= s_axis_tdata[31:0];
                yo_q    <= s_axis_tdata[63:32];
                zo_q    <= s_axis_tdata[95:64];
                io_q    <= '0;
                lo_q    <= 1'b1;
                dg_q    <= 1'b1;
                nxt_q   <= N_FIN;
                state_q <= S_OUT;
              end else begin
                cnt_q   <= INDEX_BITS'(1);
                phase_q <= PH_ONE;
              end
            end else begin
              dx_q    <= 33'($signed(s_axis_tdata[31:0])) - 33'(pend_q[0]);
              dy_q    <= 33'($signed(s_axis_tdata[63:32])) - 33'(pend_q[1]);
              job_q   <= J_DIR;
              state_q <= S_U_PREP;
            end
          end
        end
        S_U_PREP: begin
          uxn_q <= dx_q[32];
          uyn_q <= dy_q[32];
          if (uor_w[32]) begin
            ux_q <= ux_w >> 2;
            uy_q <= uy_w >> 2;
          end else if (uor_w[31]) begin
            ux_q <= ux_w >> 1;
            uy_q <= uy_w >> 1;
          end else begin
            ux_q <= ux_w;
            uy_q <= uy_w;
          end
          state_q <= S_U_MX;
        end
        S_U_MX: begin
          if (alu_rsp.done) begin
            sq_q    <= alu_rsp.res;
            state_q <= S_U_MY;
          end
        end
        S_U_MY: begin
          if (alu_rsp.done) begin
            sq_q    <= sq_q + alu_rsp.res;
            state_q <= S_U_SQ;
          end
        end
        S_U_SQ: begin
          if (alu_rsp.done) begin
            len_q <= alu_rsp.res[31:0];
            if (alu_rsp.res == '0) begin
              resx_q  <= '0;
              resy_q  <= '0;
              state_q <= S_U_END;
            end else begin
              state_q <= S_U_DX;
            end
          end
        end
        S_U_DX: begin
          if (alu_rsp.done) begin
            resx_q  <= uxn_q ? res_neg_w[31:0] : alu_rsp.res[31:0];
            state_q <= S_U_DY;
          end
        end
        S_U_DY: begin
          if (alu_rsp.done) begin
            resy_q  <= uyn_q ? res_neg_w[31:0] : alu_rsp.res[31:0];
            state_q <= S_U_END;
          end
        end
        S_U_END: begin
          unique case (job_q)
            J_DIR: begin
              d_q[0] <= resx_q;
              d_q[1] <= resy_q;
              if (phase_q == PH_ONE) begin
                fdir_q[0] <= resx_q;
                fdir_q[1] <= resy_q;
                if (!poly_q) begin
                  pt_q    <= first_q;
                  bx_q    <= resx_q;
                  by_q    <= resy_q;
                  s_q     <= ONE;
                  idx_q   <= '0;
                  olast_q <= 1'b0;
                  nxt_q   <= N_MAIN;
                  state_q <= S_P_KF;
                end else begin
                  state_q <= S_MAIN;
                end
              end else begin
                va_q    <= pdir_q;
                vb_q[0] <= resx_q;
                vb_q[1] <= resy_q;
                dx_q    <= 33'(pdir_q[0]) + 33'(resx_q);
                dy_q    <= 33'(pdir_q[1]) + 33'(resy_q);
                pt_q    <= pend_q;
                idx_q   <= cnt_q - 1'b1;
                olast_q <= 1'b0;
                nxt_q   <= N_MAIN;
                job_q   <= J_BIS;
                state_q <= S_U_PREP;
              end
            end
            J_BIS: begin
              bx_q    <= resx_q;
              by_q    <= resy_q;
              state_q <= S_M_DX;
            end
            J_CLOSE: begin
              c_q[0]  <= resx_q;
              c_q[1]  <= resy_q;
              va_q    <= d_q;
              vb_q[0] <= resx_q;
              vb_q[1] <= resy_q;
              dx_q    <= 33'(d_q[0]) + 33'(resx_q);
              dy_q    <= 33'(d_q[1]) + 33'(resy_q);
              pt_q    <= in_q;
              idx_q   <= idxp_q;
              olast_q <= 1'b0;
              nxt_q   <= N_CLOSE2;
              job_q   <= J_BIS;
              state_q <= S_U_PREP;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_M_DX: begin
          if (alu_rsp.done) begin
            dot_q   <= (va_q[0][31] ^ vb_q[0][31]) ? $signed(res_neg_w) :
                                                     $signed(alu_rsp.res);
            state_q <= S_M_DY;
          end
        end
        S_M_DY: begin
          if (alu_rsp.done) begin
            dot_q   <= (va_q[1][31] ^ vb_q[1][31]) ? dot_q - $signed(alu_rsp.res) :
                                                     dot_q + $signed(alu_rsp.res);
            state_q <= S_M_SQ;
          end
        end
        S_M_SQ: begin
          if (alu_rsp.done) begin
            s_q     <= (alu_rsp.res < MITER_MIN) ? MITER_MIN : alu_rsp.res;
            state_q <= S_P_KF;
          end
        end
        S_P_KF: begin
          if (!depth_q) begin
            kf_q    <= ONE;
            state_q <= S_P_NUM;
          end else if (alu_rsp.done) begin
            kf_q    <= alu_rsp.res;
            state_q <= S_P_NUM;
          end
        end
        S_P_NUM: begin
          if (alu_rsp.done) begin
            m_q      <= m2_w;
            numneg_q <= off_q[31];
            state_q  <= S_P_Q;
          end
        end
        S_P_Q: begin
          if (alu_rsp.done) begin
            q_q     <= (alu_rsp.res > plmo_pkg::RMAX) ? plmo_pkg::RMAX : alu_rsp.res;
            state_q <= S_P_MY;
          end
        end
        S_P_MY: begin
          if (alu_rsp.done) begin
            xo_q    <= clamp41(sumx_w);
            state_q <= S_P_MX;
          end
        end
        S_P_MX: begin
          if (alu_rsp.done) begin
            yo_q    <= clamp41(sumy_w);
            zo_q    <= pt_q[2];
            io_q    <= idx_q;
            lo_q    <= olast_q;
            dg_q    <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            unique case (nxt_q)
              N_MAIN: state_q <= S_MAIN;
              N_CLOSE2: begin
                va_q    <= c_q;
                vb_q    <= fdir_q;
                dx_q    <= 33'(c_q[0]) + 33'(fdir_q[0]);
                dy_q    <= 33'(c_q[1]) + 33'(fdir_q[1]);
                pt_q    <= first_q;
                idx_q   <= '0;
                olast_q <= 1'b1;
                nxt_q   <= N_FIN;
                job_q   <= J_BIS;
                state_q <= S_U_PREP;
              end
              N_FIN: begin
                phase_q <= PH_IDLE;
                cnt_q   <= '0;
                state_q <= S_IDLE;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_MAIN: begin
          pdir_q  <= d_q;
          pend_q  <= in_q;
          cnt_q   <= cnt_q + 1'b1;
          phase_q <= PH_RUN;
          if (!inlast_q) begin
            state_q <= S_IDLE;
          end else if (!poly_q) begin
            pt_q    <= in_q;
            bx_q    <= d_q[0];
            by_q    <= d_q[1];
            s_q     <= ONE;
            idx_q   <= cnt_q;
            olast_q <= 1'b1;
            nxt_q   <= N_FIN;
            state_q <= S_P_KF;
          end else begin
            dx_q    <= 33'(first_q[0]) - 33'(in_q[0]);
            dy_q    <= 33'(first_q[1]) - 33'(in_q[1]);
            idxp_q  <= cnt_q;
            job_q   <= J_CLOSE;
            state_q <= S_U_PREP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic [31:0] io_ext;
  assign io_ext = 32'(io_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {io_ext[15:0], zo_q, yo_q, xo_q};
  assign m_axis_tlast  = lo_q;
  assign m_axis_tuser  = dg_q;
  assign cfg_ready_o   = 1'b1;

  `PLMO_ASSERT_IMP(a_degen_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast,
                   "degenerate item without tlast")
  `PLMO_ASSERT_IMP(a_one_at_a_time, s_axis_tready, !m_axis_tvalid,
                   "input ready while a result is pending")
  `PLMO_ASSERT_IMP(a_alu_free, alu_req.start, !alu_rsp.busy,
                   "arithmetic unit started while busy")
  `PLMO_ASSERT_NXT(a_figure_end, out_acc && m_axis_tlast, phase_q == PH_IDLE,
                   "figure not closed after final item")

endmodule

/* sim/polyline_miter_offset_test.sv */
`timescale 1ns / 100ps

module polyline_miter_offset_test;

  localparam longint ONE       = 64'sd65536;
  localparam longint MITER_MIN = (ONE + 50) / 100;
  localparam int     LIMIT     = 4000000;

  typedef struct {
    int       x;
    int       y;
    int       z;
    bit [15:0] idx;
    bit       last;
    bit       degen;
  } offset_vertex_t;

  class offset_scoreboard;
    bit             polygon_mode;
    longint         offset;
    bit             depth_mode;
    int             first_pt[3];
    int             first_dir[2];
    int             held_pt[3];
    int             prev_dir[2];
    bit [15:0]      count;
    int             phase;
    offset_vertex_t expected_q[$];
    int             errors;
    int             results_seen;

    function new();
      polygon_mode = 0;
      offset = 65536;
      depth_mode = 0;
      first_pt = '{0, 0, 0};
      first_dir = '{0, 0};
      held_pt = '{0, 0, 0};
      prev_dir = '{0, 0};
      count = 0;
      phase = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [31:0] data);
      if (addr == plmo_pkg::CFG_IS_POLYGON) polygon_mode = data[0];
      else if (addr == plmo_pkg::CFG_OFFSET_AMOUNT) offset = longint'(signed'(data));
      else if (addr == plmo_pkg::CFG_DEPTH_SCALING) depth_mode = data[0];
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint scaled_mul(longint a, longint b);
      longint unsigned ua;
      longint unsigned ub;
      longint unsigned m;
      ua = mag(a);
      ub = mag(b);
      if (ua != 0 && ub > (64'd1 << 62) / ua) m = plmo_pkg::RMAX;
      else begin
        m = (ua * ub) >> 16;
        if (m > plmo_pkg::RMAX) m = plmo_pkg::RMAX;
      end
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
    endfunction

    function void direction(longint dx, longint dy, output int ox, output int oy);
      longint unsigned ux;
      longint unsigned uy;
      longint unsigned len;
      ux = mag(dx);
      uy = mag(dy);
      while ((ux | uy) >= (64'd1 << 31)) begin
        ux = ux >> 1;
        uy = uy >> 1;
      end
      len = root(ux * ux + uy * uy);
      if (len == 0) begin
        ox = 0;
        oy = 0;
        return;
      end
      ux = (ux << 16) / len;
      uy = (uy << 16) / len;
      ox = int'(dx < 0 ? -longint'(ux) : longint'(ux));
      oy = int'(dy < 0 ? -longint'(uy) : longint'(uy));
    endfunction

    function void shift_out(int p[3], longint bx, longint by, longint s,
                            bit [15:0] idx, bit last);
      offset_vertex_t v;
      longint kf;
      longint num;
      longint r;
      longint unsigned q;
      kf = ONE;
      if (depth_mode) kf = longint'((64'd1 << 32) / (1 + mag(longint'(p[2]) + 10 * ONE)));
      num = scaled_mul(kf, offset);
      q = (mag(num) << 16) / longint'(s);
      if (q > plmo_pkg::RMAX) q = plmo_pkg::RMAX;
      r = num < 0 ? -longint'(q) : longint'(q);
      v.x = sat32(longint'(p[0]) + scaled_mul(by, r));
      v.y = sat32(longint'(p[1]) - scaled_mul(bx, r));
      v.z = p[2];
      v.idx = idx;
      v.last = last;
      v.degen = 0;
      expected_q.push_back(v);
    endfunction

    function void join_at(int p[3], int din[2], int dout[2], bit [15:0] idx, bit last);
      int bx;
      int by;
      longint dot;
      longint t;
      longint s;
      direction(longint'(din[0]) + dout[0], longint'(din[1]) + dout[1], bx, by);
      dot = (longint'(din[0]) * dout[0] + longint'(din[1]) * dout[1]) >>> 16;
      t = ONE + dot;
      if (t < 0) t = 0;
      if (t > 2 * ONE) t = 2 * ONE;
      s = longint'(root(longint'(t) << 15));
      if (s < MITER_MIN) s = MITER_MIN;
      shift_out(p, bx, by, s, idx, last);
    endfunction

    function void note_vertex(int px, int py, int pz, bit last);
      int p[3];
      int d[2];
      int c[2];
      bit [15:0] idx_p;
      offset_vertex_t v;
      p = '{px, py, pz};
      if (phase == 0) begin
        first_pt = p;
        held_pt = p;
        if (last) begin
          v = '{px, py, pz, 16'd0, 1'b1, 1'b1};
          expected_q.push_back(v);
          count = 0;
          return;
        end
        count = 1;
        phase = 1;
        return;
      end
      direction(longint'(p[0]) - held_pt[0], longint'(p[1]) - held_pt[1], d[0], d[1]);
      if (phase == 1) begin
        first_dir = d;
        prev_dir = d;
        if (!polygon_mode) shift_out(first_pt, d[0], d[1], ONE, 16'd0, 1'b0);
      end else begin
        join_at(held_pt, prev_dir, d, count - 16'd1, 1'b0);
      end
      prev_dir = d;
      held_pt = p;
      idx_p = count;
      count = count + 16'd1;
      phase = 2;
      if (last) begin
        if (!polygon_mode) begin
          shift_out(held_pt, prev_dir[0], prev_dir[1], ONE, idx_p, 1'b1);
        end else begin
          direction(longint'(first_pt[0]) - held_pt[0],
                    longint'(first_pt[1]) - held_pt[1], c[0], c[1]);
          join_at(held_pt, prev_dir, c, idx_p, 1'b0);
          join_at(first_pt, c, first_dir, 16'd0, 1'b1);
        end
        phase = 0;
        count = 0;
      end
    endfunction

    function void check_vertex(offset_vertex_t got);
      offset_vertex_t w;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (got.x != w.x) begin
        $error("x_out expected %0d actual %0d", w.x, got.x);
        errors++;
      end
      if (got.y != w.y) begin
        $error("y_out expected %0d actual %0d", w.y, got.y);
        errors++;
      end
      if (got.z != w.z) begin
        $error("z_out expected %0d actual %0d", w.z, got.z);
        errors++;
      end
      if (got.idx != w.idx) begin
        $error("vertex_index expected %0d actual %0d", w.idx, got.idx);
        errors++;
      end
      if (got.last != w.last) begin
        $error("last_out expected %0d actual %0d", w.last, got.last);
        errors++;
      end
      if (got.degen != w.degen) begin
        $error("degenerate expected %0d actual %0d", w.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [0:0]   m_axis_tuser;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_data_i = '0;

  offset_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int figures = 0;
  int cfg_writes = 0;
  int prev_x, prev_y, back_x, back_y;

  polyline_miter_offset dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("polyline_miter_offset_test: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    offset_vertex_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[31:0];
      got.y = m_axis_tdata[63:32];
      got.z = m_axis_tdata[95:64];
      got.idx = m_axis_tdata[111:96];
      got.last = m_axis_tlast;
      got.degen = m_axis_tuser[0];
      sb.check_vertex(got);
    end
    case ((cycles >> 9) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= (cycles % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_vertex(int x, int y, int z, bit last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_vertex(x, y, z, last);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(addr, data);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(bit poly, logic [31:0] ofs, bit depth);
    wait_idle();
    write_reg(plmo_pkg::CFG_IS_POLYGON, {31'd0, poly});
    write_reg(plmo_pkg::CFG_OFFSET_AMOUNT, ofs);
    write_reg(plmo_pkg::CFG_DEPTH_SCALING, {31'd0, depth});
  endtask

  function automatic int pick_coord(bit wide);
    if (wide) return $urandom;
    return int'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 6))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return 32'd65536;
      4: return -32'sd65536;
      5: return $urandom;
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  task automatic random_figure(int n);
    bit wide;
    int x, y, z, sel;
    wide = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (i > 0 && sel == 0) begin
        x = prev_x;
        y = prev_y;
      end else if (i > 1 && sel == 1) begin
        x = back_x;
        y = back_y;
      end else begin
        x = pick_coord(wide);
        y = pick_coord(wide);
      end
      z = ($urandom_range(0, 3) == 0) ? $urandom : pick_coord(0);
      back_x = prev_x;
      back_y = prev_y;
      prev_x = x;
      prev_y = y;
      send_vertex(x, y, z, i == n - 1);
    end
    figures++;
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 20);

    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(10 * 65536, 0, 0, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(0, 0, 0, 0);
    send_vertex(5 * 65536, 0, 0, 0);
    send_vertex(0, 0, 0, 1);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_vertex(32'h7fffffff, 32'h80000000, 0, 1);
    figures += 5;
    setup(1, 32'h7fffffff, 0);
    send_vertex(0, 0, 0, 0);
    send_vertex(65536, 0, 0, 0);
    send_vertex(0, 65536, 0, 1);
    setup(1, 32'h80000000, 0);
    send_vertex(0, 0, 0, 0);
    send_vertex(4 * 65536, 0, 0, 0);
    send_vertex(4 * 65536, 4 * 65536, 0, 0);
    send_vertex(0, 4 * 65536, 0, 1);
    setup(1, 32'd65536, 1);
    send_vertex(0, 0, -10 * 65536, 0);
    send_vertex(65536, 65536, 0, 0);
    send_vertex(-65536, 65536, 32'h80000000, 1);
    setup(0, -32'sd65536, 1);
    send_vertex(0, 0, 32'h7fffffff, 0);
    send_vertex(65536, 0, 3 * 65536, 0);
    send_vertex(65536, 65536, -10 * 65536, 1);
    figures += 4;

    while (items_sent < 270) begin
      if ($urandom_range(0, 2) == 0)
        setup($urandom_range(0, 1), pick_offset(), $urandom_range(0, 1));
      n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
      random_figure(n);
    end
    setup(0, 32'd65536, 0);

    $display("covered %0d figures, %0d vertices, %0d results, %0d register writes",
             figures, items_sent, sb.results_seen, cfg_writes);
    $display("polygon and polyline modes, depth scaling, offset extremes, stalls on both sides");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("polyline_miter_offset_test: clean");
    end else begin
      $display("polyline_miter_offset_test: errors");
    end
    $finish;
  end

endmodule
